// ===== design/era_pkg.sv =====
// ----------------------------------------------------------------------------
// era_pkg: shared types, constants and helpers of the Euler rotation block
// Holds the angle and entry formats, the lane record that travels along the
// series cells, the reciprocal table used for the series divisions and the
// sign-magnitude helpers of the matrix products.
// ----------------------------------------------------------------------------
package era_pkg;

   // Field formats
   localparam int ANGLE_WIDTH     = 16;
   localparam int ENTRY_FRAC_BITS = 14;
   localparam int ENTRY_WIDTH     = ENTRY_FRAC_BITS + 2;

   // Phase and series formats
   localparam int PHASE_WIDTH = 32;
   localparam int RESID_BITS  = 29;
   localparam int WORK_FRAC   = 30;
   localparam int WIDE_WIDTH  = 33;

   localparam logic [31:0]         PI_QUARTER_Q32 = 32'hC90F_DAA2;
   localparam logic [32:0]         Q32_ONE        = 33'h1_0000_0000;
   localparam logic [RESID_BITS:0] RESID_FULL     = {1'b1, {RESID_BITS{1'b0}}};
   localparam logic [62:0]         ROUND_Q30      = 63'd1 << (WORK_FRAC - 1);

   // Pipeline depth, stage by stage
   localparam int CELL_COUNT    = 5;
   localparam int CELL_STAGES   = 3;
   localparam int REDUCE_STAGES = 2;
   localparam int FOLD_STAGES   = 2;
   localparam int MATRIX_STAGES = 7;
   localparam int PIPE_DEPTH    = REDUCE_STAGES + CELL_COUNT * CELL_STAGES
                                  + FOLD_STAGES + MATRIX_STAGES;

   typedef logic signed [ANGLE_WIDTH-1:0] angle_type;
   typedef logic signed [ENTRY_WIDTH-1:0] entry_type;
   typedef logic signed [WIDE_WIDTH-1:0]  wide_type;
   typedef logic [32:0]                   recip_type;
   typedef logic [2:0]                    rshift_type;

   // Record handed from cell to cell: reduced angle, its square, octant and
   // the running Horner terms of the sine and cosine series.
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] x2;
      logic [2:0]  oct;
      logic [32:0] ts;
      logic [32:0] tc;
   } lane_type;

   // Q30 value in sign-magnitude form
   typedef struct packed {
      logic        neg;
      logic [30:0] mag;
   } sm_type;

   // Unrounded product of two Q30 magnitudes
   typedef struct packed {
      logic        neg;
      logic [61:0] mag;
   } prod_type;

   typedef struct packed {
      sm_type sn;
      sm_type cs;
   } sc_type;

   typedef struct packed {
      entry_type m00;
      entry_type m01;
      entry_type m02;
      entry_type m10;
      entry_type m11;
      entry_type m12;
      entry_type m20;
      entry_type m21;
      entry_type m22;
   } rot_type;

   // Exact division by a small constant k: floor(v * M / 2^(32 + l)) with
   // M = ceil(2^(32 + l) / k) and l = ceil(log2 k). The first sine cell has
   // a zero reciprocal, which leaves its term at one.
   localparam recip_type SIN_RECIP [CELL_COUNT] = '{
      33'd0, 33'd7635497416, 33'd6544712071, 33'd6871947674, 33'd5726623062
   };
   localparam rshift_type SIN_SHIFT [CELL_COUNT] = '{3'd0, 3'd7, 3'd6, 3'd5, 3'd3};
   localparam recip_type COS_RECIP [CELL_COUNT] = '{
      33'd6108397933, 33'd4908534053, 33'd4581298450, 33'd5726623062, 33'd4294967296
   };
   localparam rshift_type COS_SHIFT [CELL_COUNT] = '{3'd7, 3'd6, 3'd5, 3'd4, 3'd1};

   // Final rounding of a Q30 entry to the output format
   localparam int       FIN_SHIFT    = WORK_FRAC - ENTRY_FRAC_BITS;
   localparam wide_type FIN_BIAS_POS = WIDE_WIDTH'((64'd1 << FIN_SHIFT) >> 1);
   localparam wide_type FIN_BIAS_NEG = WIDE_WIDTH'((64'd1 << FIN_SHIFT) - 64'd1)
                                       - FIN_BIAS_POS;
   localparam wide_type ENTRY_LIMIT  = WIDE_WIDTH'(64'd1 << ENTRY_FRAC_BITS);

   // Product of two sign-magnitude values, not yet rounded
   function automatic prod_type sm_mul(sm_type a, sm_type b);
      prod_type p;
      p.neg = a.neg ^ b.neg;
      p.mag = 62'(a.mag) * 62'(b.mag);
      return p;
   endfunction

   // Round a product back to Q30, half away from zero on the magnitude
   function automatic sm_type sm_round(prod_type p);
      logic [62:0] sum;
      sm_type      r;
      sum   = {1'b0, p.mag} + ROUND_Q30;
      r.neg = p.neg;
      r.mag = sum[WORK_FRAC +: 31];
      return r;
   endfunction

   // Sign-magnitude to two's complement
   function automatic wide_type sm_to_signed(sm_type a);
      wide_type v;
      v = signed'({2'b00, a.mag});
      return a.neg ? -v : v;
   endfunction

   // Round a Q30 entry to the output scale, half away from zero, and
   // saturate to plus or minus one.
   function automatic entry_type finish_entry(wide_type v);
      wide_type bias;
      wide_type e;
      bias = v[WIDE_WIDTH-1] ? FIN_BIAS_NEG : FIN_BIAS_POS;
      e    = (v + bias) >>> FIN_SHIFT;
      if (e > ENTRY_LIMIT) begin
         e = ENTRY_LIMIT;
      end else if (e < -ENTRY_LIMIT) begin
         e = -ENTRY_LIMIT;
      end
      return ENTRY_WIDTH'(e);
   endfunction

endpackage

// ===== design/era_reduce.sv =====
// ----------------------------------------------------------------------------
// era_reduce: angle reduction
// Maps an angle onto a 32-bit phase, splits off the octant, folds the
// residual and forms the reduced angle in Q32 radians and its square.
// ----------------------------------------------------------------------------
module era_reduce (
   input  logic              clock,
   input  logic              en,
   input  era_pkg::angle_type angle,
   output era_pkg::lane_type  lane_out
);
   import era_pkg::*;

   logic [PHASE_WIDTH-1:0] phase;
   logic [2:0]             oct;
   logic [RESID_BITS:0]    resid;
   logic [63:0]            xprod;
   logic [63:0]            sqprod;

   logic [31:0] x1_ff;
   logic [31:0] x1_in;
   logic [2:0]  oct1_ff;
   logic [31:0] x2_ff;
   logic [31:0] x2_in;
   logic [31:0] x_ff;
   logic [2:0]  oct_ff;

   // Phase, octant and the residual, mirrored in odd octants.
   always_comb begin
      phase = PHASE_WIDTH'(unsigned'(angle)) << (PHASE_WIDTH - ANGLE_WIDTH);
      oct   = phase[PHASE_WIDTH-1 -: 3];
      resid = {1'b0, phase[RESID_BITS-1:0]};
      if (oct[0]) begin
         resid = RESID_FULL - resid;
      end
      xprod = 64'(resid) * 64'(PI_QUARTER_Q32);
      x1_in = xprod[RESID_BITS +: 32];
   end

   // Square of the reduced angle in Q32.
   always_comb begin
      sqprod = 64'(x1_ff) * 64'(x1_ff);
      x2_in  = sqprod[63:32];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff   <= x1_in;
         oct1_ff <= oct;
         x2_ff   <= x2_in;
         x_ff    <= x1_ff;
         oct_ff  <= oct1_ff;
      end
   end

   // Both series start from a term of one.
   always_comb begin
      lane_out.x   = x_ff;
      lane_out.x2  = x2_ff;
      lane_out.oct = oct_ff;
      lane_out.ts  = Q32_ONE;
      lane_out.tc  = Q32_ONE;
   end

endmodule

// ===== design/era_cell.sv =====
// ----------------------------------------------------------------------------
// era_cell: one Horner step of the sine and cosine series
// Computes t' = 1 - (x2 * t) / k for both series side by side over three
// stages: product, division by reciprocal multiplication, subtraction.
// ----------------------------------------------------------------------------
module era_cell (
   input  logic                clock,
   input  logic                en,
   input  era_pkg::lane_type   lane_in,
   input  era_pkg::recip_type  recip_s,
   input  era_pkg::rshift_type shift_s,
   input  era_pkg::recip_type  recip_c,
   input  era_pkg::rshift_type shift_c,
   output era_pkg::lane_type   lane_out
);
   import era_pkg::*;

   logic [64:0] prod_s;
   logic [64:0] prod_c;
   logic [64:0] rcp_s;
   logic [64:0] rcp_c;

   lane_type lane_a_ff;
   lane_type lane_a_in;
   lane_type lane_b_ff;
   lane_type lane_b_in;
   lane_type lane_c_ff;
   lane_type lane_c_in;

   // First stage: Q32 product of the square with each running term.
   always_comb begin
      prod_s       = 65'(lane_in.x2) * 65'(lane_in.ts);
      prod_c       = 65'(lane_in.x2) * 65'(lane_in.tc);
      lane_a_in    = lane_in;
      lane_a_in.ts = {1'b0, prod_s[63:32]};
      lane_a_in.tc = {1'b0, prod_c[63:32]};
   end

   // Second stage: multiply by the scaled reciprocal of the divisor.
   always_comb begin
      rcp_s        = 65'(lane_a_ff.ts[31:0]) * 65'(recip_s);
      rcp_c        = 65'(lane_a_ff.tc[31:0]) * 65'(recip_c);
      lane_b_in    = lane_a_ff;
      lane_b_in.ts = rcp_s[64:32];
      lane_b_in.tc = rcp_c[64:32];
   end

   // Third stage: finish the quotient and subtract it from one.
   always_comb begin
      lane_c_in    = lane_b_ff;
      lane_c_in.ts = Q32_ONE - (lane_b_ff.ts >> shift_s);
      lane_c_in.tc = Q32_ONE - (lane_b_ff.tc >> shift_c);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_a_ff <= lane_a_in;
         lane_b_ff <= lane_b_in;
         lane_c_ff <= lane_c_in;
      end
   end

   assign lane_out = lane_c_ff;

endmodule

// ===== design/era_fold.sv =====
// ----------------------------------------------------------------------------
// era_fold: series completion and octant fold
// Closes the sine series with a final multiplication by x, rounds both
// results to Q30 and picks and signs them according to the octant.
// ----------------------------------------------------------------------------
module era_fold (
   input  logic              clock,
   input  logic              en,
   input  era_pkg::lane_type lane_in,
   output era_pkg::sc_type   sc_out
);
   import era_pkg::*;

   logic [64:0] prod;
   logic [31:0] s_a_ff;
   logic [31:0] s_a_in;
   logic [32:0] c_a_ff;
   logic [2:0]  oct_a_ff;
   logic [30:0] mag_s;
   logic [30:0] mag_c;
   logic        swap;
   sc_type      sc_ff;
   sc_type      sc_in;

   // Sine is x times the last sine term.
   always_comb begin
      prod   = 65'(lane_in.x) * 65'(lane_in.ts);
      s_a_in = prod[63:32];
   end

   // Round to Q30; octants one, two, five and six swap sine and cosine,
   // the upper half negates the sine, the middle quarters the cosine.
   always_comb begin
      mag_s         = 31'(({1'b0, s_a_ff} + 33'd2) >> 2);
      mag_c         = 31'((34'(c_a_ff) + 34'd2) >> 2);
      swap          = oct_a_ff[0] ^ oct_a_ff[1];
      sc_in.sn.mag  = swap ? mag_c : mag_s;
      sc_in.sn.neg  = oct_a_ff[2];
      sc_in.cs.mag  = swap ? mag_s : mag_c;
      sc_in.cs.neg  = oct_a_ff[2] ^ oct_a_ff[1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_a_ff   <= s_a_in;
         c_a_ff   <= lane_in.tc;
         oct_a_ff <= lane_in.oct;
         sc_ff    <= sc_in;
      end
   end

   assign sc_out = sc_ff;

endmodule

// ===== design/era_matrix.sv =====
// ----------------------------------------------------------------------------
// era_matrix: rotation matrix assembly
// Forms the pairwise and triple products of the sines and cosines, adds the
// terms of each entry and rounds and saturates the nine entries.
// ----------------------------------------------------------------------------
module era_matrix (
   input  logic             clock,
   input  logic             en,
   input  era_pkg::sc_type  roll,
   input  era_pkg::sc_type  pitch,
   input  era_pkg::sc_type  yaw,
   output era_pkg::rot_type rot_out
);
   import era_pkg::*;

   // Pairwise products
   localparam int L1_COUNT = 10;
   localparam int SRSP = 0;
   localparam int CRSP = 1;
   localparam int CPCY = 2;
   localparam int CPSY = 3;
   localparam int SRCP = 4;
   localparam int CRCP = 5;
   localparam int CRSY = 6;
   localparam int CRCY = 7;
   localparam int SRSY = 8;
   localparam int SRCY = 9;

   // Triple products
   localparam int L2_COUNT = 4;
   localparam int SRSP_CY  = 0;
   localparam int SRSP_SY  = 1;
   localparam int CRSP_CY  = 2;
   localparam int CRSP_SY  = 3;

   // Entries
   localparam int ENTRY_COUNT = 9;
   localparam int E00 = 0;
   localparam int E01 = 1;
   localparam int E02 = 2;
   localparam int E10 = 3;
   localparam int E11 = 4;
   localparam int E12 = 5;
   localparam int E20 = 6;
   localparam int E21 = 7;
   localparam int E22 = 8;

   sm_type   opa [L1_COUNT];
   sm_type   opb [L1_COUNT];
   sm_type   l2a [L2_COUNT];
   sm_type   l2b [L2_COUNT];
   wide_type sum_in [ENTRY_COUNT];

   prod_type l1p_ff [L1_COUNT];
   sm_type   sp1_ff;
   sm_type   sy1_ff;
   sm_type   cy1_ff;
   sm_type   l1_ff [L1_COUNT];
   sm_type   sp2_ff;
   sm_type   sy2_ff;
   sm_type   cy2_ff;
   prod_type l2p_ff [L2_COUNT];
   sm_type   l1d3_ff [L1_COUNT];
   sm_type   sp3_ff;
   sm_type   l2_ff [L2_COUNT];
   sm_type   l1d4_ff [L1_COUNT];
   sm_type   sp4_ff;
   wide_type l2s_ff [L2_COUNT];
   wide_type l1s_ff [L1_COUNT];
   wide_type sp5_ff;
   wide_type sum_ff [ENTRY_COUNT];
   rot_type  rot_ff;

   // Operands of the pairwise products.
   always_comb begin
      opa[SRSP] = roll.sn;   opb[SRSP] = pitch.sn;
      opa[CRSP] = roll.cs;   opb[CRSP] = pitch.sn;
      opa[CPCY] = pitch.cs;  opb[CPCY] = yaw.cs;
      opa[CPSY] = pitch.cs;  opb[CPSY] = yaw.sn;
      opa[SRCP] = roll.sn;   opb[SRCP] = pitch.cs;
      opa[CRCP] = roll.cs;   opb[CRCP] = pitch.cs;
      opa[CRSY] = roll.cs;   opb[CRSY] = yaw.sn;
      opa[CRCY] = roll.cs;   opb[CRCY] = yaw.cs;
      opa[SRSY] = roll.sn;   opb[SRSY] = yaw.sn;
      opa[SRCY] = roll.sn;   opb[SRCY] = yaw.cs;
   end

   // Operands of the triple products, built on the rounded pairs.
   always_comb begin
      l2a[SRSP_CY] = l1_ff[SRSP];  l2b[SRSP_CY] = cy2_ff;
      l2a[SRSP_SY] = l1_ff[SRSP];  l2b[SRSP_SY] = sy2_ff;
      l2a[CRSP_CY] = l1_ff[CRSP];  l2b[CRSP_CY] = cy2_ff;
      l2a[CRSP_SY] = l1_ff[CRSP];  l2b[CRSP_SY] = sy2_ff;
   end

   // Entry sums; a sum of two rounded terms is exact.
   always_comb begin
      sum_in[E00] = l1s_ff[CPCY];
      sum_in[E01] = -l1s_ff[CPSY];
      sum_in[E02] = sp5_ff;
      sum_in[E10] = l2s_ff[SRSP_CY] + l1s_ff[CRSY];
      sum_in[E11] = l1s_ff[CRCY] - l2s_ff[SRSP_SY];
      sum_in[E12] = -l1s_ff[SRCP];
      sum_in[E20] = l1s_ff[SRSY] - l2s_ff[CRSP_CY];
      sum_in[E21] = l2s_ff[CRSP_SY] + l1s_ff[SRCY];
      sum_in[E22] = l1s_ff[CRCP];
   end

   // Seven stages: pair products, rounding, triple products, rounding,
   // conversion to two's complement, entry sums, output rounding.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < L1_COUNT; i++) begin
            l1p_ff[i]  <= sm_mul(opa[i], opb[i]);
            l1_ff[i]   <= sm_round(l1p_ff[i]);
            l1d3_ff[i] <= l1_ff[i];
            l1d4_ff[i] <= l1d3_ff[i];
            l1s_ff[i]  <= sm_to_signed(l1d4_ff[i]);
         end
         for (int j = 0; j < L2_COUNT; j++) begin
            l2p_ff[j] <= sm_mul(l2a[j], l2b[j]);
            l2_ff[j]  <= sm_round(l2p_ff[j]);
            l2s_ff[j] <= sm_to_signed(l2_ff[j]);
         end
         for (int k = 0; k < ENTRY_COUNT; k++) begin
            sum_ff[k] <= sum_in[k];
         end
         sp1_ff <= pitch.sn;
         sy1_ff <= yaw.sn;
         cy1_ff <= yaw.cs;
         sp2_ff <= sp1_ff;
         sy2_ff <= sy1_ff;
         cy2_ff <= cy1_ff;
         sp3_ff <= sp2_ff;
         sp4_ff <= sp3_ff;
         sp5_ff <= sm_to_signed(sp4_ff);
         rot_ff.m00 <= finish_entry(sum_ff[E00]);
         rot_ff.m01 <= finish_entry(sum_ff[E01]);
         rot_ff.m02 <= finish_entry(sum_ff[E02]);
         rot_ff.m10 <= finish_entry(sum_ff[E10]);
         rot_ff.m11 <= finish_entry(sum_ff[E11]);
         rot_ff.m12 <= finish_entry(sum_ff[E12]);
         rot_ff.m20 <= finish_entry(sum_ff[E20]);
         rot_ff.m21 <= finish_entry(sum_ff[E21]);
         rot_ff.m22 <= finish_entry(sum_ff[E22]);
      end
   end

   assign rot_out = rot_ff;

endmodule

// ===== design/euler_angles_to_rotation_top.sv =====
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_top: rotation matrix from roll, pitch and yaw
// Gives the nine entries of Rx(roll) * Ry(pitch) * Rz(yaw) in signed Q1.14.
//
// Usage:
//  - Request channel (req_valid / req_ready) carries three angles in binary
//    angle units, where half the full scale stands for pi.
//  - Response channel (rsp_valid / rsp_ready) carries the entries m00..m22,
//    saturated to plus or minus one.
//  - Depth: 26 register stages (2 reduction, 5 series cells of 3 stages,
//    2 fold, 7 matrix).
//  - Throughput: one angle triple per cycle when not stalled; every stage is a
//    register in a single pipeline and each item advances one stage per cycle.
//  - When the receiver stalls with a result waiting, every stage holds,
//    empty ones included, and req_ready falls until the result is taken.
//  - Reset empties the pipeline and holds req_ready low; no result is
//    presented until new requests arrive. There are no configuration registers.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  era_pkg::angle_type req_roll_angle,
   input  era_pkg::angle_type req_pitch_angle,
   input  era_pkg::angle_type req_yaw_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output era_pkg::entry_type rsp_m00,
   output era_pkg::entry_type rsp_m01,
   output era_pkg::entry_type rsp_m02,
   output era_pkg::entry_type rsp_m10,
   output era_pkg::entry_type rsp_m11,
   output era_pkg::entry_type rsp_m12,
   output era_pkg::entry_type rsp_m20,
   output era_pkg::entry_type rsp_m21,
   output era_pkg::entry_type rsp_m22
);
   import era_pkg::*;

   localparam int NUM_AXES   = 3;
   localparam int AXIS_ROLL  = 0;
   localparam int AXIS_PITCH = 1;
   localparam int AXIS_YAW   = 2;

   logic                  en;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;
   angle_type             angle_w [NUM_AXES];
   lane_type              lane_w [NUM_AXES][CELL_COUNT+1];
   sc_type                sc_w [NUM_AXES];
   rot_type               rot_w;

   // The pipeline advances unless a finished result is waiting and not taken.
   assign en        = ~vld_ff[PIPE_DEPTH-1] | rsp_ready;
   assign req_ready = en & ~reset;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];
   assign vld_in    = {vld_ff[PIPE_DEPTH-2:0], req_valid};

   // Occupancy of each pipeline stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign angle_w[AXIS_ROLL]  = req_roll_angle;
   assign angle_w[AXIS_PITCH] = req_pitch_angle;
   assign angle_w[AXIS_YAW]   = req_yaw_angle;

   // One sine and cosine lane per axis: reduction, a row of series cells,
   // then the octant fold.
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      era_reduce u_reduce (
         .clock    (clock),
         .en       (en),
         .angle    (angle_w[a]),
         .lane_out (lane_w[a][0])
      );

      for (genvar c = 0; c < CELL_COUNT; c++) begin : g_cell
         era_cell u_cell (
            .clock    (clock),
            .en       (en),
            .lane_in  (lane_w[a][c]),
            .recip_s  (SIN_RECIP[c]),
            .shift_s  (SIN_SHIFT[c]),
            .recip_c  (COS_RECIP[c]),
            .shift_c  (COS_SHIFT[c]),
            .lane_out (lane_w[a][c+1])
         );
      end

      era_fold u_fold (
         .clock   (clock),
         .en      (en),
         .lane_in (lane_w[a][CELL_COUNT]),
         .sc_out  (sc_w[a])
      );
   end

   // Products, sums and output rounding.
   era_matrix u_matrix (
      .clock   (clock),
      .en      (en),
      .roll    (sc_w[AXIS_ROLL]),
      .pitch   (sc_w[AXIS_PITCH]),
      .yaw     (sc_w[AXIS_YAW]),
      .rot_out (rot_w)
   );

   assign rsp_m00 = rot_w.m00;
   assign rsp_m01 = rot_w.m01;
   assign rsp_m02 = rot_w.m02;
   assign rsp_m10 = rot_w.m10;
   assign rsp_m11 = rot_w.m11;
   assign rsp_m12 = rot_w.m12;
   assign rsp_m20 = rot_w.m20;
   assign rsp_m21 = rot_w.m21;
   assign rsp_m22 = rot_w.m22;

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Euler angle to rotation matrix block
// A queue of angle triples (a directed set of corner angles, then random
// triples biased towards octant boundaries) feeds a burst-and-gap driver.
// Every request transfer is turned into an expected matrix by a bit-exact
// fixed-point model held in this file. Each response transfer is checked
// entry by entry against the oldest expected matrix. The receiver stalls on
// patterns of its own and once holds off long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module tb_top;

   import era_pkg::*;

   // Watchdog limit, in cycles without any transfer
   localparam int IDLE_LIMIT    = 3000;
   localparam int RANDOM_ITEMS  = 1580;
   localparam int DRAIN_CYCLES  = 40;
   localparam int LONG_HOLD     = 300;
   localparam int HOLD_AFTER    = 300;

   localparam bit [63:0] Q32_UNIT = 64'h1_0000_0000;

   typedef struct packed {
      angle_type roll;
      angle_type pitch;
      angle_type yaw;
   } angle_triple_type;

   typedef struct packed {
      longint sn;
      longint cs;
   } trig_type;

   typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE} rx_mode_type;

   logic      clock;
   logic      reset           = 1'b1;
   logic      req_valid       = 1'b0;
   logic      req_ready;
   angle_type req_roll_angle  = '0;
   angle_type req_pitch_angle = '0;
   angle_type req_yaw_angle   = '0;
   logic      rsp_valid;
   logic      rsp_ready       = 1'b0;
   entry_type rsp_m00, rsp_m01, rsp_m02;
   entry_type rsp_m10, rsp_m11, rsp_m12;
   entry_type rsp_m20, rsp_m21, rsp_m22;

   angle_triple_type angle_q [$];
   rot_type          awaited_matrices [$];

   bit failed         = 1'b0;
   int idle_cycles    = 0;
   int results_seen   = 0;

   euler_angles_to_rotation_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_roll_angle  (req_roll_angle),
      .req_pitch_angle (req_pitch_angle),
      .req_yaw_angle   (req_yaw_angle),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_m00         (rsp_m00),
      .rsp_m01         (rsp_m01),
      .rsp_m02         (rsp_m02),
      .rsp_m10         (rsp_m10),
      .rsp_m11         (rsp_m11),
      .rsp_m12         (rsp_m12),
      .rsp_m20         (rsp_m20),
      .rsp_m21         (rsp_m21),
      .rsp_m22         (rsp_m22)
   );

   // ------------------------------------------------------------------------
   // Fixed-point rotation model
   // ------------------------------------------------------------------------

   // Unsigned Q32 product, truncated.
   function automatic bit [63:0] q32_product(bit [63:0] a, bit [63:0] b);
      return (a * b) >> 32;
   endfunction

   // Round a Q32 magnitude to Q30 and apply the sign.
   function automatic longint q30_from_q32(bit [63:0] mag, bit neg);
      longint m;
      m = longint'((mag + 64'd2) >> 2);
      return neg ? -m : m;
   endfunction

   // Shift right with rounding half away from zero, worked on the magnitude.
   function automatic longint round_half_away(longint v, int sh);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (longint'(1) << (sh - 1))) >> sh;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic longint q30_product(longint a, longint b);
      return round_half_away(a * b, WORK_FRAC);
   endfunction

   // Sine and cosine in Q30 from octant reduction and a Horner series.
   function automatic trig_type sine_cosine(angle_type ang);
      bit [31:0] phase;
      bit [2:0]  oct;
      bit [63:0] resid, x, x2, t, s, c;
      bit        swap;
      trig_type  sc;
      phase = {ang, {(32 - ANGLE_WIDTH){1'b0}}};
      oct   = phase[31:29];
      resid = 64'(phase[28:0]);
      // Odd octants measure the residual from the far end.
      if (oct[0]) begin
         resid = (64'd1 << RESID_BITS) - resid;
      end
      x  = (resid * 64'(PI_QUARTER_Q32)) >> RESID_BITS;
      x2 = q32_product(x, x);

      t = Q32_UNIT - x2 / 72;
      t = Q32_UNIT - q32_product(x2, t) / 42;
      t = Q32_UNIT - q32_product(x2, t) / 20;
      t = Q32_UNIT - q32_product(x2, t) / 6;
      s = q32_product(x, t);

      t = Q32_UNIT - x2 / 90;
      t = Q32_UNIT - q32_product(x2, t) / 56;
      t = Q32_UNIT - q32_product(x2, t) / 30;
      t = Q32_UNIT - q32_product(x2, t) / 12;
      c = Q32_UNIT - q32_product(x2, t) / 2;

      // Octants 1, 2, 5 and 6 swap the two series; the upper half negates
      // the sine and the second and third quadrants negate the cosine.
      swap  = oct[0] ^ oct[1];
      sc.sn = q30_from_q32(swap ? c : s, oct[2]);
      sc.cs = q30_from_q32(swap ? s : c, oct[1] ^ oct[2]);
      return sc;
   endfunction

   // Round a Q30 entry to the output scale and saturate to plus or minus one.
   function automatic entry_type entry_of(longint v);
      longint lim, e;
      lim = longint'(1) << ENTRY_FRAC_BITS;
      e   = round_half_away(v, WORK_FRAC - ENTRY_FRAC_BITS);
      if (e > lim) begin
         e = lim;
      end else if (e < -lim) begin
         e = -lim;
      end
      return entry_type'(e);
   endfunction

   // Rx(roll) * Ry(pitch) * Rz(yaw), triple products taken left to right.
   function automatic rot_type rotation_of(angle_type roll, angle_type pitch,
                                           angle_type yaw);
      trig_type r, p, y;
      longint   srsp, crsp;
      rot_type  m;
      r    = sine_cosine(roll);
      p    = sine_cosine(pitch);
      y    = sine_cosine(yaw);
      srsp = q30_product(r.sn, p.sn);
      crsp = q30_product(r.cs, p.sn);
      m.m00 = entry_of(q30_product(p.cs, y.cs));
      m.m01 = entry_of(-q30_product(p.cs, y.sn));
      m.m02 = entry_of(p.sn);
      m.m10 = entry_of(q30_product(srsp, y.cs) + q30_product(r.cs, y.sn));
      m.m11 = entry_of(q30_product(r.cs, y.cs) - q30_product(srsp, y.sn));
      m.m12 = entry_of(-q30_product(r.sn, p.cs));
      m.m20 = entry_of(q30_product(r.sn, y.sn) - q30_product(crsp, y.cs));
      m.m21 = entry_of(q30_product(crsp, y.sn) + q30_product(r.sn, y.cs));
      m.m22 = entry_of(q30_product(r.cs, p.cs));
      return m;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic void add_angles(int roll, int pitch, int yaw);
      angle_triple_type a;
      a.roll  = angle_type'(roll);
      a.pitch = angle_type'(pitch);
      a.yaw   = angle_type'(yaw);
      angle_q.push_back(a);
   endfunction

   // Mostly uniform angles, some close to octant boundaries, some near zero.
   function automatic int pick_angle();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
         return int'($urandom);
      end else if (sel < 9) begin
         return int'($urandom_range(0, 7)) * 8192 + int'($urandom_range(0, 8)) - 4;
      end else begin
         return int'($urandom_range(0, 128)) - 64;
      end
   endfunction

   task automatic check_entry(string label, entry_type want, entry_type got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
         failed = 1'b1;
      end
   endtask

   // ------------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      // Directed corners: zero, full scale, pi from both sides, octant
      // boundaries, alternating bit patterns and mixed signs.
      add_angles(0, 0, 0);
      add_angles(32767, 32767, 32767);
      add_angles(-32768, -32768, -32768);
      add_angles(-32768, 0, 0);
      add_angles(0, -32768, 0);
      add_angles(0, 0, -32768);
      add_angles(8192, 8192, 8192);
      add_angles(16384, 16384, 16384);
      add_angles(24576, -24576, 24576);
      add_angles(-16384, -8192, -16384);
      add_angles(16384, 0, 0);
      add_angles(0, 16384, 0);
      add_angles(0, 0, 16384);
      add_angles(16383, 16385, -16383);
      add_angles(8191, 8193, -8191);
      add_angles(1, -1, 32767);
      add_angles(16'h5555, 16'hAAAA, 16'h5555);
      add_angles(16'hAAAA, 16'h5555, 16'hAAAA);
      add_angles(16'h00FF, 16'hFF00, 16'h0F0F);
      add_angles(-1, -1, -1);
      add_angles(-16384, 16384, -32768);
      add_angles(4096, 12288, 20480);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         add_angles(pick_angle(), pick_angle(), pick_angle());
      end

      wait (!reset);
      @(negedge clock);
      while (angle_q.size() != 0 || req_valid || awaited_matrices.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (!failed) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog: ends the run when nothing has moved for too long.
   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(negedge clock);
      end
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request driver: bursts of random length separated by random gaps
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      angle_triple_type a;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_valid || req_ready) begin
         // The offered triple, if any, has just been transferred.
         if (gap_left != 0 || angle_q.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
            end
         end else begin
            a = angle_q.pop_front();
            req_valid       <= 1'b1;
            req_roll_angle  <= a.roll;
            req_pitch_angle <= a.pitch;
            req_yaw_angle   <= a.yaw;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response stall pattern, with one long hold-off to fill the pipeline
   // ------------------------------------------------------------------------
   rx_mode_type rx_mode   = RX_STEADY;
   int          rx_left   = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_mode   <= RX_STEADY;
         rx_left   <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 2));
            rx_left <= $urandom_range(20, 200);
         end else begin
            rx_left <= rx_left - 1;
         end
         case (rx_mode)
            RX_STEADY: begin
               rsp_ready <= 1'b1;
            end
            RX_COIN: begin
               rsp_ready <= ($urandom_range(0, 1) == 1);
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predicts on each request transfer, checks each response
   // transfer against the oldest expected matrix.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rot_type want;
      if (reset) begin
         idle_cycles  <= 0;
         results_seen <= 0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_matrices.push_back(
               rotation_of(req_roll_angle, req_pitch_angle, req_yaw_angle));
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_matrices.size() == 0) begin
               $display("%0t: response transfer with no matrix expected", $time);
               failed = 1'b1;
            end else begin
               want = awaited_matrices.pop_front();
               check_entry("m00", want.m00, rsp_m00);
               check_entry("m01", want.m01, rsp_m01);
               check_entry("m02", want.m02, rsp_m02);
               check_entry("m10", want.m10, rsp_m10);
               check_entry("m11", want.m11, rsp_m11);
               check_entry("m12", want.m12, rsp_m12);
               check_entry("m20", want.m20, rsp_m20);
               check_entry("m21", want.m21, rsp_m21);
               check_entry("m22", want.m22, rsp_m22);
            end
            results_seen <= results_seen + 1;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

endmodule
